// ----- rtl/hes_pkg.sv -----
// ----------------------------------------------------------------------------
// hes_pkg
// Shared types and constants for the streamed explicit heat equation step.
// ----------------------------------------------------------------------------
package hes_pkg;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned GAIN_W  = 16;
   localparam int unsigned LAP_W   = 34;   // left + right - 2*center, exact
   localparam int unsigned PROD_W  = LAP_W + GAIN_W + 1;
   localparam int unsigned SUM_W   = 64;
   localparam int unsigned ROOT_W  = 32;
   localparam int unsigned FRAC_W  = 16;

   // Input request payload
   typedef struct packed {
      logic signed [VALUE_W-1:0] old_value;
      logic signed [VALUE_W-1:0] boundary_value;
      logic                      last_point;
   } req_type;

   // Result payload
   typedef struct packed {
      logic signed [VALUE_W-1:0] new_value;
      logic [ROOT_W-1:0]         change_norm;
      logic                      row_done;
   } rsp_type;

   // What the back end has to do for one request
   typedef enum logic [1:0] {
      OP_NONE,       // no point result, only the row end (if last)
      OP_PASS,       // left end passes through
      OP_INTERIOR    // interior update of the previous point
   } op_kind_type;

   typedef struct packed {
      op_kind_type               kind;
      logic signed [VALUE_W-1:0] value;     // pass value or center sample
      logic signed [LAP_W-1:0]   lap;
      logic signed [VALUE_W-1:0] boundary;
      logic                      last;
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_SAT,
      ST_DIFF,
      ST_SQ,
      ST_ACC,
      ST_EMIT_INT,
      ST_SQRT,
      ST_EMIT_LAST,
      ST_EMIT_PASS
   } back_state_type;

   localparam logic [1:0] POINTS_NONE = 2'd0;
   localparam logic [1:0] POINTS_ONE  = 2'd1;
   localparam logic [1:0] POINTS_TWO  = 2'd2;

endpackage

// ----- rtl/hes_front.sv -----
// ----------------------------------------------------------------------------
// hes_front
// Accepts grid points, keeps the three-sample window and turns each request
// that yields a point or ends a row into one back-end op, laplacian formed.
// ----------------------------------------------------------------------------
module hes_front
   import hes_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    push,
   output op_type  push_op,
   input  logic    queue_full
);

   logic [1:0]                points_ff, points_in;
   logic signed [VALUE_W-1:0] left_ff, left_in;
   logic signed [VALUE_W-1:0] center_ff, center_in;
   logic                      accept;
   logic signed [LAP_W-1:0]   lap;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // Laplacian with the incoming point as right neighbor
   assign lap = LAP_W'(left_ff) + LAP_W'(req_data.old_value)
              - (LAP_W'(center_ff) <<< 1);

   // Classify the request and advance the window
   always_comb begin
      points_in        = points_ff;
      left_in          = left_ff;
      center_in        = center_ff;
      push_op.kind     = OP_NONE;
      push_op.value    = req_data.old_value;
      push_op.lap      = lap;
      push_op.boundary = req_data.boundary_value;
      push_op.last     = req_data.last_point;
      if (points_ff == POINTS_NONE) begin
         if (!req_data.last_point) begin
            push_op.kind = OP_PASS;
         end
         center_in = req_data.old_value;
         points_in = POINTS_ONE;
      end else if (points_ff == POINTS_ONE) begin
         left_in   = center_ff;
         center_in = req_data.old_value;
         points_in = POINTS_TWO;
      end else begin
         push_op.kind  = OP_INTERIOR;
         push_op.value = center_ff;
         left_in       = center_ff;
         center_in     = req_data.old_value;
      end
      if (req_data.last_point) begin
         left_in   = '0;
         center_in = '0;
         points_in = POINTS_NONE;
      end
   end

   assign push = accept && ((push_op.kind != OP_NONE) || req_data.last_point);

   always_ff @(posedge clock) begin
      if (reset) begin
         points_ff <= POINTS_NONE;
         left_ff   <= '0;
         center_ff <= '0;
      end else if (accept) begin
         points_ff <= points_in;
         left_ff   <= left_in;
         center_ff <= center_in;
      end
   end

endmodule

// ----- rtl/hes_queue.sv -----
// ----------------------------------------------------------------------------
// hes_queue
// Small register queue of operations between the front and back ends.
// ----------------------------------------------------------------------------
module hes_queue
   import hes_pkg::*;
#(
   parameter int unsigned DEPTH = 4   // power of two, at least 2
)
(
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   output logic   full,
   input  logic   pop,
   output op_type head,
   output logic   empty
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   op_type             entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

// ----- rtl/hes_back.sv -----
// ----------------------------------------------------------------------------
// hes_back
// Executes queued operations: interior update with rounding and saturation,
// squared-change accumulation, bit-serial square root and the result register.
// ----------------------------------------------------------------------------
module hes_back
   import hes_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [GAIN_W-1:0] step_gain,
   input  logic              queue_empty,
   input  op_type            head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data
);

   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (FRAC_W - 1);
   localparam int unsigned DELTA_W = PROD_W - FRAC_W;
   localparam int unsigned NV_W    = DELTA_W + 1;
   localparam int unsigned REM_W   = ROOT_W + 1;
   localparam int unsigned CNT_W   = $clog2(ROOT_W);
   localparam logic signed [NV_W-1:0] NV_MAX = NV_W'(32'sh7FFF_FFFF);
   localparam logic signed [NV_W-1:0] NV_MIN = NV_W'(32'sh8000_0000);

   back_state_type             state_ff, state_in;
   op_type                     op_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [VALUE_W-1:0]  nv_ff;
   logic [VALUE_W-1:0]         mag_ff;
   logic [SUM_W-1:0]           sq_ff;
   logic [SUM_W-1:0]           sum_ff;
   logic [SUM_W-1:0]           rad_ff;
   logic [REM_W-1:0]           rem_ff, rem_in;
   logic [ROOT_W-1:0]          root_ff, root_in;
   logic [CNT_W-1:0]           cnt_ff;
   logic                       rsp_valid_ff;
   rsp_type                    rsp_data_ff;

   logic                       slot_free;
   logic                       load_rsp;
   logic                       start_sqrt;
   logic signed [DELTA_W-1:0]  delta;
   logic signed [NV_W-1:0]     nv_wide;
   logic signed [VALUE_W-1:0]  nv_sat;
   logic signed [VALUE_W:0]    diff;
   logic [SUM_W:0]             sum_wide;
   logic [REM_W+1:0]           rem_sh;
   logic [REM_W+1:0]           trial;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               unique case (head.kind)
                  OP_PASS:     state_in = ST_EMIT_PASS;
                  OP_INTERIOR: state_in = ST_MUL;
                  default:     state_in = ST_SQRT;
               endcase
            end
         end
         ST_MUL:  state_in = ST_SAT;
         ST_SAT:  state_in = ST_DIFF;
         ST_DIFF: state_in = ST_SQ;
         ST_SQ:   state_in = ST_ACC;
         ST_ACC:  state_in = ST_EMIT_INT;
         ST_EMIT_INT: begin
            if (slot_free) begin
               state_in = op_ff.last ? ST_SQRT : ST_IDLE;
            end
         end
         ST_SQRT: begin
            if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
               state_in = ST_EMIT_LAST;
            end
         end
         ST_EMIT_LAST, ST_EMIT_PASS: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control strobes
   always_comb begin
      pop        = 1'b0;
      load_rsp   = 1'b0;
      start_sqrt = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            pop        = !queue_empty;
            start_sqrt = !queue_empty && (head.kind == OP_NONE);
         end
         ST_EMIT_INT: begin
            load_rsp   = slot_free;
            start_sqrt = slot_free && op_ff.last;
         end
         ST_EMIT_LAST, ST_EMIT_PASS: load_rsp = slot_free;
         default: ;
      endcase
   end

   // Rounded gain term and saturated new value
   assign delta   = DELTA_W'((prod_ff + ROUND_HALF) >>> FRAC_W);
   assign nv_wide = NV_W'(delta) + NV_W'(op_ff.value);
   always_comb begin
      if (nv_wide > NV_MAX) begin
         nv_sat = VALUE_W'(NV_MAX);
      end else if (nv_wide < NV_MIN) begin
         nv_sat = VALUE_W'(NV_MIN);
      end else begin
         nv_sat = VALUE_W'(nv_wide);
      end
   end

   assign diff     = (VALUE_W + 1)'(nv_ff) - (VALUE_W + 1)'(op_ff.value);
   assign sum_wide = {1'b0, sum_ff} + {1'b0, sq_ff};

   // One root bit per cycle
   assign rem_sh = {rem_ff, rad_ff[SUM_W-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};
   always_comb begin
      if (rem_sh >= trial) begin
         rem_in  = REM_W'(rem_sh - trial);
         root_in = {root_ff[ROOT_W-2:0], 1'b1};
      end else begin
         rem_in  = REM_W'(rem_sh);
         root_in = {root_ff[ROOT_W-2:0], 1'b0};
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (pop) begin
         op_ff <= head;
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= PROD_W'(op_ff.lap) * PROD_W'($signed({1'b0, step_gain}));
      end
      if (state_ff == ST_SAT) begin
         nv_ff <= nv_sat;
      end
      if (state_ff == ST_DIFF) begin
         mag_ff <= diff[VALUE_W] ? VALUE_W'(-diff) : VALUE_W'(diff);
      end
      if (state_ff == ST_SQ) begin
         sq_ff <= SUM_W'(mag_ff) * SUM_W'(mag_ff);
      end
      if (start_sqrt) begin
         rad_ff  <= sum_ff;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (state_ff == ST_SQRT) begin
         rad_ff  <= rad_ff << 2;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
      if (load_rsp) begin
         unique case (state_ff)
            ST_EMIT_INT: begin
               rsp_data_ff.new_value   <= nv_ff;
               rsp_data_ff.change_norm <= '0;
               rsp_data_ff.row_done    <= 1'b0;
            end
            ST_EMIT_LAST: begin
               rsp_data_ff.new_value   <= op_ff.boundary;
               rsp_data_ff.change_norm <= root_ff;
               rsp_data_ff.row_done    <= 1'b1;
            end
            default: begin
               rsp_data_ff.new_value   <= op_ff.value;
               rsp_data_ff.change_norm <= '0;
               rsp_data_ff.row_done    <= 1'b0;
            end
         endcase
      end
   end

   // Control state and running sum
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_ACC) begin
            sum_ff <= sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
         end else if (state_ff == ST_EMIT_LAST && slot_free) begin
            sum_ff <= '0;
         end
         if (start_sqrt) begin
            cnt_ff <= '0;
         end else if (state_ff == ST_SQRT) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/heat_equation_explicit_step.sv -----
// The back-end sequencer handles one queued operation at a time. An interior point
// steps through pop, multiply, round/saturate, difference, square, accumulate and
// emit; the row end adds a 32-step square root plus emit. The emit states wait while
// a result is held and not taken. The 4-deep queue runs ahead.
// ----------------------------------------------------------------------------
// heat_equation_explicit_step
// Streamed explicit time step of the 1-D heat equation with change norm.
// ----------------------------------------------------------------------------
module heat_equation_explicit_step
   import hes_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_wr_en,
   input  logic [GAIN_W-1:0] csr_wr_data
);

   // Reset: synchronous, active high; clears window, queue, sum, gain, output.

   logic [GAIN_W-1:0] gain_ff;
   logic              push;
   op_type            push_op;
   logic              queue_full;
   logic              queue_empty;
   logic              pop;
   op_type            head;

   // Gain register
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= '0;
      end else if (csr_wr_en) begin
         gain_ff <= csr_wr_data;
      end
   end

   hes_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push       (push),
      .push_op    (push_op),
      .queue_full (queue_full)
   );

   hes_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .full    (queue_full),
      .pop     (pop),
      .head    (head),
      .empty   (queue_empty)
   );

   hes_back u_back (
      .clock       (clock),
      .reset       (reset),
      .step_gain   (gain_ff),
      .queue_empty (queue_empty),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule
